// File: hdl/ptcs_pkg.sv
// Shared constants and types for the piece tracker and choke selector.
`default_nettype none
package ptcs_pkg;
   localparam int MAX_PIECES_DEF    = 1024;
   localparam int MAX_GATES_DEF     = 64;
   localparam int COUNT_BITS_DEF    = 32;
   localparam int UNCHOKE_SLOTS_DEF = 4;

   localparam logic [1:0] CMD_PIECE   = 2'd0;
   localparam logic [1:0] CMD_REQUEST = 2'd1;
   localparam logic [1:0] CMD_REQTICK = 2'd2;
   localparam logic [1:0] CMD_CHOKE   = 2'd3;

   localparam logic [2:0] ACT_UPDATE  = 3'd0;
   localparam logic [2:0] ACT_SEND    = 3'd1;
   localparam logic [2:0] ACT_REQUEST = 3'd2;
   localparam logic [2:0] ACT_UNCHOKE = 3'd3;
   localparam logic [2:0] ACT_CHOKE   = 3'd4;

   localparam logic [1:0] REG_NUM_PIECES = 2'd0;
   localparam logic [1:0] REG_SEEDER     = 2'd1;
   localparam logic [1:0] REG_GATE_COUNT = 2'd2;

   typedef struct packed {
      logic [2:0] action;
      logic [9:0] piece_out;
      logic [7:0] target_gate;
      logic       download_done;
      logic       last_result;
   } rsp_type;
endpackage
`default_nettype wire

// File: hdl/piece_tracker_choke_selector_unit.sv
// Top level of the piece tracker and choke selector.
// Work per transaction: a piece request reads the bitmap once; a received piece also scans
// the bitmap for completion; a request tick scans it for a missing piece; a choke tick runs
// one ranking pass over the gate counters for each result it gives.
// Transactions are handled one at a time; the next one is accepted once the work has ended.
// After reset a clearing pass zeroes both memories.
`default_nettype none
module piece_tracker_choke_selector_unit
   import ptcs_pkg::*;
#(
   parameter int MAX_PIECES    = MAX_PIECES_DEF,
   parameter int MAX_GATES     = MAX_GATES_DEF,
   parameter int COUNT_BITS    = COUNT_BITS_DEF,
   parameter int UNCHOKE_SLOTS = UNCHOKE_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[1:0], piece_number[17:2], arrival_gate[25:18], peer_known[26],
   // chosen_peer[34:27], zero fill to 40 bits
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // action[2:0], piece_out[12:3], target_gate[20:13], download_done[21], zero fill
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data
);
   localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int GW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
   localparam int NW = GW + 1;
   localparam int CLRN = (MAX_PIECES > MAX_GATES) ? MAX_PIECES : MAX_GATES;
   localparam int CW = $clog2(CLRN + 1);
   localparam int SW = $clog2(UNCHOKE_SLOTS + 2);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001, S_IDLE = 10'b0000000010, S_RD = 10'b0000000100,
      S_EVAL  = 10'b0000001000, S_SCAN = 10'b0000010000, S_CHK = 10'b0000100000,
      S_RANK  = 10'b0001000000, S_ROUT = 10'b0010000000, S_OPT = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0] num_pieces_ff;
   logic        seeder_ff;
   logic [6:0]  gate_cnt_ff;

   logic [1:0]  cmd_ff;
   logic [15:0] piece_ff;
   logic [7:0]  agate_ff;
   logic        known_ff;
   logic [7:0]  peer_ff;

   logic [CW-1:0] idx_ff, idx_in;
   logic [16:0]   np, ng;

   // Bitmap and counter memories, read data registered.
   logic                  have_mem [MAX_PIECES];
   logic [COUNT_BITS-1:0] cnt_mem  [MAX_GATES];
   logic                  have_q;
   logic [COUNT_BITS-1:0] cnt_q;
   logic                  hwe, hrd;
   logic [PW-1:0]         haddr;
   logic [PW-1:0]         hwaddr;
   logic                  hwd;
   logic                  cwe;
   logic [GW-1:0]         caddr;
   logic [COUNT_BITS-1:0] cwd;

   logic [MAX_GATES-1:0]  taken_ff;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic [GW-1:0]         best_ff;
   logic                  best_ok_ff;
   logic [SW-1:0]         slot_ff;
   logic [CW-1:0]         sidx_ff;
   logic [NW-1:0]         nz_ff;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_v_ff;
   logic    rsp_load;
   logic    req_fire;
   logic    rank_last;

   assign np = (num_pieces_ff > 11'(MAX_PIECES)) ? 17'(MAX_PIECES) : 17'(num_pieces_ff);
   assign ng = (gate_cnt_ff > 7'(MAX_GATES)) ? 17'(MAX_GATES) : 17'(gate_cnt_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = rsp_ff.last_result;
   assign rsp_tdata  = {2'b0, rsp_ff.download_done, rsp_ff.target_gate,
                        rsp_ff.piece_out, rsp_ff.action};

   // A ranked result is final when no optimistic unchoke follows and no further
   // nonzero counter is left or every slot is filled.
   assign rank_last = !known_ff && (slot_ff == SW'(UNCHOKE_SLOTS) ||
                      NW'(slot_ff) + 1'b1 == nz_ff);

   always_ff @(posedge clock) begin
      if (hwe) have_mem[hwaddr] <= hwd;
      if (hrd) have_q <= have_mem[haddr];
      if (cwe) cnt_mem[caddr] <= cwd;
      cnt_q <= cnt_mem[caddr];
   end

   logic held_now;
   assign held_now = seeder_ff || have_q;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      hwe = 1'b0; hrd = 1'b0; hwd = 1'b0;
      haddr = piece_ff[PW-1:0];
      hwaddr = piece_ff[PW-1:0];
      cwe = 1'b0; cwd = cnt_q;
      caddr = agate_ff[GW-1:0];
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_CLEAR: begin
            hwe = (idx_ff < CW'(MAX_PIECES)); hwd = 1'b0;
            hwaddr = idx_ff[PW-1:0];
            cwe = (idx_ff < CW'(MAX_GATES)); cwd = '0;
            caddr = idx_ff[GW-1:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(CLRN - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) state_in = S_RD;
         end
         S_RD: begin
            idx_in = '0;
            unique case (cmd_ff)
               CMD_PIECE, CMD_REQUEST: begin
                  if (17'(piece_ff) < np) begin
                     hrd = 1'b1; state_in = S_EVAL;
                  end else state_in = S_IDLE;
               end
               CMD_REQTICK: begin
                  if (np == 17'd0) state_in = S_IDLE;
                  else begin
                     hrd = 1'b1; haddr = '0; state_in = S_SCAN;
                  end
               end
               default: state_in = S_RANK;
            endcase
         end
         S_EVAL: begin
            if (cmd_ff == CMD_PIECE) begin
               if (held_now) state_in = S_IDLE;
               else begin
                  hwe = 1'b1; hwd = 1'b1;
                  rsp_in = '{ACT_UPDATE, piece_ff[9:0], 8'd0, 1'b0, 1'b1};
                  hrd = 1'b1; haddr = '0; idx_in = '0;
                  state_in = S_CHK;
               end
            end else begin
               if (held_now && 17'(agate_ff) < ng) begin
                  // Counter read issued in S_RD state path; cnt_q holds agate entry.
                  rsp_in = '{ACT_SEND, piece_ff[9:0], agate_ff, 1'b0, 1'b1};
                  cwe = (cnt_q != CMAX); cwd = cnt_q + 1'b1;
                  state_in = S_OUT;
               end else state_in = S_IDLE;
            end
         end
         S_CHK: begin
            // Completion check after a write; the just-written bit reads as held.
            if (!(held_now || idx_ff == CW'(piece_ff))) begin
               state_in = S_OUT;
            end else if (17'(idx_ff) + 17'd1 >= np) begin
               rsp_in.download_done = 1'b1; state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1; hrd = 1'b1; haddr = PW'(idx_ff + 1'b1);
            end
         end
         S_SCAN: begin
            if (!held_now) begin
               if (known_ff && 17'(peer_ff) < ng) begin
                  rsp_in = '{ACT_REQUEST, idx_ff[9:0], peer_ff, 1'b0, 1'b1};
                  state_in = S_OUT;
               end else state_in = S_IDLE;
            end else if (17'(idx_ff) + 17'd1 >= np) state_in = S_IDLE;
            else begin
               idx_in = idx_ff + 1'b1; hrd = 1'b1; haddr = PW'(idx_ff + 1'b1);
            end
         end
         S_RANK: begin
            caddr = sidx_ff[GW-1:0];
            if (sidx_ff == CW'(MAX_GATES)) state_in = S_ROUT;
         end
         S_ROUT: begin
            if (!rsp_v_ff || rsp_tready) begin
               if (!best_ok_ff || slot_ff == SW'(UNCHOKE_SLOTS + 1)) begin
                  if (known_ff) begin
                     rsp_in = '{ACT_UNCHOKE, 10'd0, peer_ff, 1'b0, 1'b1};
                     state_in = S_OUT;
                  end else state_in = S_IDLE;
               end else begin
                  rsp_in = '{(slot_ff < SW'(UNCHOKE_SLOTS)) ? ACT_UNCHOKE : ACT_CHOKE,
                             10'd0, 8'(best_ff), 1'b0, rank_last};
                  state_in = S_OPT;
               end
            end
         end
         S_OPT: state_in = S_RANK;
         S_OUT: begin
            if (!rsp_v_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE) caddr = req_tdata[18+GW-1:18];
   end

   assign rsp_load = ((state_ff == S_EVAL || state_ff == S_CHK || state_ff == S_SCAN ||
                       state_ff == S_ROUT) && state_in == S_OUT) ||
                     (state_ff == S_ROUT && state_in == S_OPT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         rsp_v_ff      <= 1'b0;
         num_pieces_ff <= 11'd1024;
         seeder_ff     <= 1'b0;
         gate_cnt_ff   <= 7'd64;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_NUM_PIECES: num_pieces_ff <= csr_data;
               REG_SEEDER:     seeder_ff     <= csr_data[0];
               REG_GATE_COUNT: gate_cnt_ff   <= csr_data[6:0];
               default: ;
            endcase
         end
         rsp_v_ff <= rsp_load || (rsp_v_ff && !rsp_tready);
      end
   end

   // Payload registers and ranking pass.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tdata[1:0];
         piece_ff <= req_tdata[17:2];
         agate_ff <= req_tdata[25:18];
         known_ff <= req_tdata[26];
         peer_ff  <= req_tdata[34:27];
         taken_ff <= '0;
         slot_ff  <= '0;
         nz_ff    <= '0;
      end
      if (state_ff == S_EVAL || state_ff == S_CHK || state_ff == S_SCAN ||
          state_ff == S_ROUT) rsp_ff <= rsp_in;
      if (state_ff == S_RD || state_ff == S_OPT) begin
         sidx_ff     <= '0;
         best_ok_ff  <= 1'b0;
         best_cnt_ff <= '0;
      end
      if (state_ff == S_OPT) begin
         taken_ff[best_ff] <= 1'b1;
         slot_ff <= slot_ff + 1'b1;
      end
      if (state_ff == S_RANK) begin
         sidx_ff <= sidx_ff + 1'b1;
         // cnt_q holds the entry addressed in the previous cycle.
         if (sidx_ff != '0) begin
            // The first pass also counts the nonzero counters.
            if (slot_ff == '0 && cnt_q != '0) nz_ff <= nz_ff + 1'b1;
            if (!taken_ff[GW'(sidx_ff - 1'b1)] && cnt_q != '0 &&
                (!best_ok_ff || cnt_q > best_cnt_ff)) begin
               best_ok_ff  <= 1'b1;
               best_cnt_ff <= cnt_q;
               best_ff     <= GW'(sidx_ff - 1'b1);
            end
         end
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_v_ff)
      else $error("result pending while ready");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready) else $error("accept while clearing");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> rsp_v_ff) else $error("result dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while waiting");
endmodule
`default_nettype wire
